// ----- hdl/number_to_ascii_converter_defines.svh -----
// Assertion macros for the number to ASCII converter
`ifndef NUMBER_TO_ASCII_CONVERTER_DEFINES_SVH
`define NUMBER_TO_ASCII_CONVERTER_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent
`define NTA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nta check failed");

// Check the consequent in the cycle after the antecedent
`define NTA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nta check failed");

`endif

// ----- hdl/nta_pkg.sv -----
// Shared types, constants and helpers for the number to ASCII converter
`timescale 1ns / 1ps
package nta_pkg;

  localparam int MaxDigits = 10;
  localparam int CountW    = 4;

  localparam logic [1:0] MODE_CHAR = 2'd0;
  localparam logic [1:0] MODE_DEC  = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;
  localparam logic [1:0] MODE_INV  = 2'd3;

  localparam logic [31:0] Recip10   = 32'hCCCC_CCCD;
  localparam logic [7:0]  Ascii0    = 8'd48;
  localparam logic [7:0]  AsciiX    = 8'h58;
  localparam logic [7:0]  HexAlphaOff = 8'd87;
  localparam logic [3:0]  DigitMask = 4'hF;
  localparam logic [31:0] DecLimit  = 32'd9;
  localparam logic [31:0] HexLimit  = 32'd15;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHAR,
    S_CONV,
    S_PFX0,
    S_PFXX,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [31:0] quot;
    logic [3:0]  digit;
    logic        final_digit;
  } step_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [3:0] m;
    m = d & DigitMask;
    if (m <= 4'd9) begin
      digit_char = {4'd0, m} + Ascii0;
    end else begin
      digit_char = {4'd0, m} + HexAlphaOff;
    end
  endfunction

endpackage

// ----- hdl/nta_digit_unit.sv -----
// Shared digit extraction unit: divide by ten or shift by one nibble
`timescale 1ns / 1ps
module nta_digit_unit (
  input  logic [31:0]         t,
  input  logic                hex,
  output nta_pkg::step_t      step
);

  logic [63:0] prod;
  logic [31:0] q10;
  logic [31:0] dec_q;
  logic [31:0] dec_r;

  assign prod  = {32'd0, t} * {32'd0, nta_pkg::Recip10};
  assign dec_q = {3'd0, prod[63:35]};
  assign q10   = (dec_q << 3) + (dec_q << 1);
  assign dec_r = t - q10;

  always_comb begin
    if (hex) begin
      step.quot        = t >> 4;
      step.digit       = t[3:0];
      step.final_digit = (t <= nta_pkg::HexLimit);
    end else begin
      step.quot        = dec_q;
      step.digit       = dec_r[3:0];
      step.final_digit = (t <= nta_pkg::DecLimit);
    end
  end

endmodule

// ----- hdl/number_to_ascii_converter.sv -----
// Top level of the number to ASCII converter
//
// Input channel: mode and value, taken when in_valid is high and in_stall is
// low. Output channel: ascii_char and last, one character per word, most
// significant first; last marks the final word of a conversion.
// Character mode gives one word (none for a zero byte). Decimal mode gives the
// digits without leading zeros. Hex mode gives "0X" and lowercase digits.
// Invalid mode gives nothing.
// One item is handled at a time: in_stall stays high from acceptance until the
// final word is loaded into the output register.
// Digits come from one shared unit, one digit per cycle (a reciprocal multiply
// for decimal, a nibble shift for hex). Emission then sends the characters in
// order, holding while the receiver stalls.
// When the receiver stalls, the output word holds and the sequencer waits.
// Reset (synchronous, rst high) returns to idle and drops any pending word.
`timescale 1ns / 1ps
`include "number_to_ascii_converter_defines.svh"
module number_to_ascii_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  ascii_char,
  output logic        last
);

  nta_pkg::state_t state;
  nta_pkg::state_t state_next;

  logic [31:0]                 t;
  logic                        is_hex;
  logic [nta_pkg::CountW-1:0]  count;
  logic [3:0]                  digits [nta_pkg::MaxDigits];
  nta_pkg::step_t              step;

  logic       out_free;
  logic       take;
  logic       step_en;
  logic       emit_en;
  logic       pop;
  logic [7:0] emit_char;
  logic       emit_last;

  nta_digit_unit u_digit (
    .t    (t),
    .hex  (is_hex),
    .step (step)
  );

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != nta_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nta_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    take       = 1'b0;
    step_en    = 1'b0;
    emit_en    = 1'b0;
    pop        = 1'b0;
    emit_char  = nta_pkg::Ascii0;
    emit_last  = 1'b0;
    unique case (state)
      nta_pkg::S_IDLE: begin
        if (in_valid) begin
          take = 1'b1;
          priority if (mode == nta_pkg::MODE_CHAR && value[7:0] != 8'd0) begin
            state_next = nta_pkg::S_CHAR;
          end else if (mode == nta_pkg::MODE_DEC || mode == nta_pkg::MODE_HEX) begin
            state_next = nta_pkg::S_CONV;
          end else begin
            state_next = nta_pkg::S_IDLE;
          end
        end
      end
      nta_pkg::S_CHAR: begin
        if (out_free) begin
          emit_en    = 1'b1;
          emit_char  = t[7:0];
          emit_last  = 1'b1;
          state_next = nta_pkg::S_IDLE;
        end
      end
      nta_pkg::S_CONV: begin
        step_en = 1'b1;
        if (step.final_digit) begin
          state_next = is_hex ? nta_pkg::S_PFX0 : nta_pkg::S_EMIT;
        end
      end
      nta_pkg::S_PFX0: begin
        if (out_free) begin
          emit_en    = 1'b1;
          emit_char  = nta_pkg::Ascii0;
          state_next = nta_pkg::S_PFXX;
        end
      end
      nta_pkg::S_PFXX: begin
        if (out_free) begin
          emit_en    = 1'b1;
          emit_char  = nta_pkg::AsciiX;
          state_next = nta_pkg::S_EMIT;
        end
      end
      nta_pkg::S_EMIT: begin
        if (out_free) begin
          emit_en   = 1'b1;
          pop       = 1'b1;
          emit_char = nta_pkg::digit_char(digits[0]);
          emit_last = (count == nta_pkg::CountW'(1));
          if (count == nta_pkg::CountW'(1)) begin
            state_next = nta_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = nta_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (emit_en) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      priority if (take) begin
        count <= '0;
      end else if (step_en) begin
        count <= count + nta_pkg::CountW'(1);
      end else if (pop) begin
        count <= count - nta_pkg::CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      t      <= value;
      is_hex <= (mode == nta_pkg::MODE_HEX);
    end else if (step_en) begin
      t <= step.quot;
    end
    if (emit_en) begin
      ascii_char <= emit_char;
      last       <= emit_last;
    end
    if (step_en) begin
      digits[0] <= step.digit;
      for (int i = 1; i < nta_pkg::MaxDigits; i++) begin
        digits[i] <= digits[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < nta_pkg::MaxDigits - 1; i++) begin
        digits[i] <= digits[i+1];
      end
    end
  end

  `NTA_ASSERT_NEXT(a_busy_after_take,
    in_valid && !in_stall && (mode == nta_pkg::MODE_DEC || mode == nta_pkg::MODE_HEX),
    in_stall && !out_valid || in_stall)
  `NTA_ASSERT_SAME(a_emit_has_digits, state == nta_pkg::S_EMIT, count != '0)
  `NTA_ASSERT_SAME(a_count_bound, 1'b1, count <= nta_pkg::CountW'(nta_pkg::MaxDigits))
  `NTA_ASSERT_NEXT(a_last_frees_input, emit_en && emit_last, !in_stall)

endmodule
